// ===== rtl/gkc_pkg.sv =====
// Shared constants, types and functions of the Gabor kernel coefficient core.
`default_nettype none

package gkc_pkg;

  localparam int MAX_SIDE = 64;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int XT_W = SIDE_W + 1;
  localparam int COORD_W = 6;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int CW = 19;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic signed [CW-1:0] CORDIC_START = 19'sd39797;
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [15:0] THETA_TO_TURN = 16'd41722;
  localparam logic [21:0] PSI_TO_TURN = 22'd2670205;

  localparam int ROT_W = 25;
  localparam int DIV_W = 28;
  localparam int DIVN_W = 32;
  localparam int NUM_W = 56;
  localparam int E_W = 20;

  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam logic [E_W-1:0] ENV_LIMIT = 20'd786432;
  localparam int LN2_STEPS = 17;
  localparam int N_W = 5;
  localparam int EXP_ORDER = 6;
  localparam logic [16:0] EXP_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_WIDTH  = 3'd0,
    REG_KERNEL_HEIGHT = 3'd1,
    REG_WAVELENGTH    = 3'd2,
    REG_ORIENTATION   = 3'd3,
    REG_PHASE_OFFSET  = 3'd4,
    REG_SPREAD        = 3'd5,
    REG_ASPECT_RATIO  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } cordic_t;

  typedef struct packed {
    logic [DIV_W-1:0]  rem;
    logic [DIVN_W-1:0] num;
  } div_t;

  typedef struct packed {
    logic [15:0] r;
    logic [16:0] p;
  } exp_t;

  function automatic logic signed [CW-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic signed [CW-1:0] a;
    case (i)
      4'd0:    a = 19'sd51472;
      4'd1:    a = 19'sd30385;
      4'd2:    a = 19'sd16055;
      4'd3:    a = 19'sd8150;
      4'd4:    a = 19'sd4091;
      4'd5:    a = 19'sd2047;
      4'd6:    a = 19'sd1024;
      4'd7:    a = 19'sd512;
      4'd8:    a = 19'sd256;
      4'd9:    a = 19'sd128;
      4'd10:   a = 19'sd64;
      4'd11:   a = 19'sd32;
      4'd12:   a = 19'sd16;
      4'd13:   a = 19'sd8;
      4'd14:   a = 19'sd4;
      default: a = 19'sd2;
    endcase
    return a;
  endfunction

  // Folds a turn angle into the right half plane and sets up the rotation.
  function automatic cordic_t cordic_init(input logic [15:0] turn);
    logic signed [16:0] t;
    logic [14:0] mag;
    logic [33:0] prod;
    logic [17:0] zmag;
    cordic_t c;
    c.flip = 1'b0;
    t = $signed({1'b0, turn});
    if (turn >= 16'd16384 && turn < 16'd49152) begin
      t = $signed({1'b0, turn}) - 17'sd32768;
      c.flip = 1'b1;
    end else if (turn >= 16'd49152) begin
      t = $signed({1'b1, turn});
    end
    mag = t[16] ? 15'(-t) : 15'(t);
    prod = 34'(mag) * 34'(TWO_PI_Q16);
    zmag = prod[33:16];
    c.z = t[16] ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
    c.x = CORDIC_START;
    c.y = '0;
    return c;
  endfunction

  function automatic logic [24:0] exp_recip(input logic [2:0] k);
    logic [24:0] m;
    case (k)
      3'd2:    m = 25'd8388608;
      3'd3:    m = 25'd5592405;
      3'd4:    m = 25'd4194304;
      3'd5:    m = 25'd3355443;
      3'd6:    m = 25'd2796202;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gkc_cordic_cell.sv =====
// One registered rotation step of the sine and cosine CORDIC chain.
`default_nettype none

module gkc_cordic_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [gkc_pkg::STEP_W-1:0] step,
  input  gkc_pkg::cordic_t          d,
  output gkc_pkg::cordic_t          q
);
  import gkc_pkg::*;

  cordic_t q_next;

  always_comb begin
    q_next = d;
    if (!d.z[CW-1]) begin
      q_next.x = d.x - ($signed(d.y) >>> step);
      q_next.y = d.y + ($signed(d.x) >>> step);
      q_next.z = d.z - atan_q16(step);
    end else begin
      q_next.x = d.x + ($signed(d.y) >>> step);
      q_next.y = d.y - ($signed(d.x) >>> step);
      q_next.z = d.z + atan_q16(step);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gkc_div_cell.sv =====
// One registered quotient bit of a restoring long division chain.
`default_nettype none

module gkc_div_cell (
  input  logic                     clk,
  input  logic                     en,
  input  logic [gkc_pkg::DIV_W-1:0] divisor,
  input  gkc_pkg::div_t            d,
  output gkc_pkg::div_t            q
);
  import gkc_pkg::*;

  logic [DIV_W-1:0] sh;
  logic [DIV_W:0]   diff;
  div_t             q_next;

  always_comb begin
    sh = {d.rem[DIV_W-2:0], d.num[DIVN_W-1]};
    diff = {1'b0, sh} - {1'b0, divisor};
    if (!diff[DIV_W]) begin
      q_next.rem = diff[DIV_W-1:0];
      q_next.num = {d.num[DIVN_W-2:0], 1'b1};
    end else begin
      q_next.rem = sh;
      q_next.num = {d.num[DIVN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gkc_exp_cell.sv =====
// One three-stage Horner step of the exponential polynomial.
`default_nettype none

module gkc_exp_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [2:0]    k,
  input  gkc_pkg::exp_t d,
  output gkc_pkg::exp_t q
);
  import gkc_pkg::*;

  logic [32:0] prod_rp;
  logic [40:0] prod_m;
  logic [18:0] rem;
  logic [15:0] quo;

  logic [15:0] r_a;
  logic [15:0] v_a;
  logic [15:0] r_b;
  logic [15:0] v_b;
  logic [15:0] q0_b;

  always_comb begin
    prod_rp = 33'(d.r) * 33'(d.p);
    prod_m = 41'(v_a) * 41'(exp_recip(k));
    rem = 19'(v_b) - 19'(q0_b) * 19'(k);
    quo = (rem >= 19'(k)) ? q0_b + 16'd1 : q0_b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_a <= d.r;
      v_a <= prod_rp[31:16];
      r_b <= r_a;
      v_b <= v_a;
      q0_b <= prod_m[39:24];
      q.r <= r_b;
      q.p <= EXP_ONE - {1'b0, quo};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gabor_kernel_coefficient_core.sv =====
// Top level of the Gabor kernel coefficient core: configuration and pipeline.
`default_nettype none

// The core returns one Gabor coefficient per (column, row) transaction and accepts a
// new transaction every cycle unless a finished result is stalled at the output. The
// pipeline is a chain of cells: two 16-step CORDIC chains, a 32-bit phase division
// and a 20-bit envelope division, one bit per cell, and six three-stage Horner cells
// for the exponential. The whole chain advances together and holds only while a
// finished result waits at the output. Configuration registers are written through
// the cfg channel, which is always ready, and must only change while no transaction
// is in flight.
module gabor_kernel_coefficient_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gkc_pkg::COORD_W-1:0]   column,
  input  logic [gkc_pkg::COORD_W-1:0]   row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            coefficient,
  output logic                          in_range,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gkc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gkc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gkc_pkg::*;

  localparam int LAST = 69;
  localparam int ROT_D = 17;
  localparam int PDIV_N = 32;
  localparam int EDIV_N = 20;
  localparam int XS_D = 18;
  localparam int ENV_D = 6;

  logic [6:0]  kernel_width;
  logic [6:0]  kernel_height;
  logic [14:0] wavelength;
  logic [15:0] orientation;
  logic [13:0] phase_offset;
  logic [12:0] spread;
  logic [11:0] aspect_ratio;

  logic [15:0]      theta_turn;
  logic [15:0]      psi_turn;
  logic [DIV_W-1:0] den;
  logic [32:0]      theta_sum;
  logic [36:0]      psi_sum;
  logic [12:0]      sig;
  logic [25:0]      sig2;
  logic [14:0]      lam;
  logic [DIV_W-1:0] lam_div;

  logic en;

  logic [LAST:0] vld;
  logic          ir_d [0:LAST];

  logic [SIDE_W-1:0]       w;
  logic [SIDE_W-1:0]       h;
  logic                    ir0;
  logic signed [XT_W-1:0]  xt0;
  logic signed [XT_W-1:0]  yt0;
  logic signed [XT_W-1:0]  xt_d [0:ROT_D];
  logic signed [XT_W-1:0]  yt_d [0:ROT_D];

  cordic_t th0;
  cordic_t th [0:CORDIC_STEPS];

  logic signed [CW-1:0]    ct;
  logic signed [CW-1:0]    st;
  logic signed [ROT_W-1:0] xr_c;
  logic signed [ROT_W-1:0] yr_c;
  logic signed [ROT_W-1:0] xr;
  logic signed [ROT_W-1:0] yr;

  logic [23:0] mx_c;
  logic [23:0] my_c;
  logic [15:0] ax_r;
  logic [27:0] aygam;
  logic [31:0] ax2;
  logic [NUM_W-1:0] g2;
  logic [NUM_W-1:0] env_num;

  div_t pdiv0;
  div_t pdiv [0:PDIV_N];
  logic xneg_d [0:PDIV_N];

  div_t ediv0;
  div_t ediv [0:EDIV_N];
  logic big_d [0:EDIV_N];

  logic [E_W-1:0] e_c;
  logic [E_W-1:0] e_r;
  logic [N_W-1:0] n_c;
  logic [N_W-1:0] n43;
  logic           big43;

  exp_t xs0;
  exp_t xs [0:EXP_ORDER];
  logic [N_W-1:0] n_d [0:XS_D];
  logic           bigx_d [0:XS_D];
  logic [16:0]    env_d [0:ENV_D];

  logic [15:0] qs;
  logic [15:0] phi;
  cordic_t     ph0;
  cordic_t     ph [0:CORDIC_STEPS];

  logic signed [CW-1:0] cph;
  logic [CW-1:0]        cmag;
  logic [36:0]          mprod;
  logic [19:0]          m;
  logic signed [15:0]   coef_c;

  assign cfg_ready = 1'b1;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_width <= 7'd10;
      kernel_height <= 7'd10;
      wavelength <= 15'd5120;
      orientation <= 16'd0;
      phase_offset <= 14'd0;
      spread <= 13'd1280;
      aspect_ratio <= 12'd128;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KERNEL_WIDTH:  kernel_width <= cfg_data[6:0];
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[6:0];
        REG_WAVELENGTH:    wavelength <= cfg_data[14:0];
        REG_ORIENTATION:   orientation <= cfg_data;
        REG_PHASE_OFFSET:  phase_offset <= cfg_data[13:0];
        REG_SPREAD:        spread <= cfg_data[12:0];
        REG_ASPECT_RATIO:  aspect_ratio <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    theta_sum = 33'(orientation) * 33'(THETA_TO_TURN) + 33'd32768;
    psi_sum = 37'(phase_offset) * 37'(PSI_TO_TURN) + 37'd32768;
    sig = (spread == '0) ? 13'd1 : spread;
    sig2 = 26'(sig) * 26'(sig);
    lam = (wavelength == '0) ? 15'd1 : wavelength;
    lam_div = DIV_W'(lam);
  end

  always_ff @(posedge clk) begin
    theta_turn <= theta_sum[31:16];
    psi_turn <= psi_sum[31:16];
    den <= DIV_W'({sig2, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], in_valid};
      out_valid <= vld[LAST];
    end
  end

  always_comb begin
    w = (kernel_width > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(kernel_width);
    h = (kernel_height > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(kernel_height);
    ir0 = (SIDE_W'(column) < w) && (SIDE_W'(row) < h);
    xt0 = $signed(XT_W'(w >> 1) - XT_W'(column));
    yt0 = $signed(XT_W'(h >> 1) - XT_W'(row));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ir_d[0] <= ir0;
      for (int k = 1; k <= LAST; k++) begin
        ir_d[k] <= ir_d[k-1];
      end
      xt_d[0] <= xt0;
      yt_d[0] <= yt0;
      for (int k = 1; k <= ROT_D; k++) begin
        xt_d[k] <= xt_d[k-1];
        yt_d[k] <= yt_d[k-1];
      end
      th0 <= cordic_init(theta_turn);
    end
  end

  assign th[0] = th0;
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_theta
    gkc_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (STEP_W'(i)),
      .d    (th[i]),
      .q    (th[i+1])
    );
  end

  always_comb begin
    ct = th[CORDIC_STEPS].flip ? -th[CORDIC_STEPS].x : th[CORDIC_STEPS].x;
    st = th[CORDIC_STEPS].flip ? -th[CORDIC_STEPS].y : th[CORDIC_STEPS].y;
    xr_c = ROT_W'(xt_d[ROT_D]) * ROT_W'(ct) + ROT_W'(yt_d[ROT_D]) * ROT_W'(st);
    yr_c = ROT_W'(yt_d[ROT_D]) * ROT_W'(ct) - ROT_W'(xt_d[ROT_D]) * ROT_W'(st);
    mx_c = xr[ROT_W-1] ? 24'(-xr) : 24'(xr);
    my_c = yr[ROT_W-1] ? 24'(-yr) : 24'(yr);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr <= xr_c;
      yr <= yr_c;
      ax_r <= mx_c[23:8];
      aygam <= 28'(my_c[23:8]) * 28'(aspect_ratio);
      ax2 <= 32'(ax_r) * 32'(ax_r);
      g2 <= NUM_W'(aygam) * NUM_W'(aygam);
      env_num <= NUM_W'({ax2, 16'd0}) + g2;
      pdiv0.rem <= '0;
      pdiv0.num <= {mx_c, 8'd0};
      xneg_d[0] <= xr[ROT_W-1];
      for (int k = 1; k <= PDIV_N; k++) begin
        xneg_d[k] <= xneg_d[k-1];
      end
      ediv0.rem <= env_num[20 +: DIV_W];
      ediv0.num <= {env_num[19:0], 12'd0};
      big_d[0] <= env_num >= NUM_W'({den, 20'd0});
      for (int k = 1; k <= EDIV_N; k++) begin
        big_d[k] <= big_d[k-1];
      end
    end
  end

  assign pdiv[0] = pdiv0;
  for (genvar i = 0; i < PDIV_N; i++) begin : g_pdiv
    gkc_div_cell u_cell (
      .clk     (clk),
      .en      (en),
      .divisor (lam_div),
      .d       (pdiv[i]),
      .q       (pdiv[i+1])
    );
  end

  assign ediv[0] = ediv0;
  for (genvar i = 0; i < EDIV_N; i++) begin : g_ediv
    gkc_div_cell u_cell (
      .clk     (clk),
      .en      (en),
      .divisor (den),
      .d       (ediv[i]),
      .q       (ediv[i+1])
    );
  end

  always_comb begin
    e_c = ediv[EDIV_N].num[E_W-1:0];
    n_c = '0;
    for (int k = 1; k <= LN2_STEPS; k++) begin
      if (e_c >= E_W'(k) * E_W'(LN2_Q16)) begin
        n_c = n_c + N_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= e_c;
      n43 <= n_c;
      big43 <= big_d[EDIV_N] || (e_c >= ENV_LIMIT);
      xs0.r <= 16'(e_r - E_W'(n43) * E_W'(LN2_Q16));
      xs0.p <= EXP_ONE;
      n_d[0] <= n43;
      bigx_d[0] <= big43;
      for (int k = 1; k <= XS_D; k++) begin
        n_d[k] <= n_d[k-1];
        bigx_d[k] <= bigx_d[k-1];
      end
      env_d[0] <= bigx_d[XS_D] ? 17'd0 : (xs[EXP_ORDER].p >> n_d[XS_D]);
      for (int k = 1; k <= ENV_D; k++) begin
        env_d[k] <= env_d[k-1];
      end
    end
  end

  assign xs[0] = xs0;
  for (genvar j = 0; j < EXP_ORDER; j++) begin : g_exp
    gkc_exp_cell u_cell (
      .clk (clk),
      .en  (en),
      .k   (3'(EXP_ORDER - j)),
      .d   (xs[j]),
      .q   (xs[j+1])
    );
  end

  always_comb begin
    qs = pdiv[PDIV_N].num[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phi <= (xneg_d[PDIV_N] ? 16'(-qs) : qs) + psi_turn;
      ph0 <= cordic_init(phi);
    end
  end

  assign ph[0] = ph0;
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_phase
    gkc_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (STEP_W'(i)),
      .d    (ph[i]),
      .q    (ph[i+1])
    );
  end

  always_comb begin
    cph = ph[CORDIC_STEPS].flip ? -ph[CORDIC_STEPS].x : ph[CORDIC_STEPS].x;
    cmag = cph[CW-1] ? CW'(-cph) : CW'(cph);
    mprod = 37'(env_d[ENV_D]) * 37'(cmag) + 37'd65536;
    m = mprod[36:17];
    if (!ir_d[LAST]) begin
      coef_c = '0;
    end else if (cph[CW-1]) begin
      coef_c = (m > 20'd32768) ? -16'sd32768 : $signed(16'(20'd0 - m));
    end else begin
      coef_c = (m > 20'd32767) ? 16'sd32767 : $signed(m[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coefficient <= coef_c;
      in_range <= ir_d[LAST];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gkc_checker.sv =====
// Port-level assertions for the Gabor kernel coefficient core and their binding.
`default_nettype none

module gkc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] coefficient,
  input logic        in_range
);

  a_zero_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> coefficient == 16'd0)
    else $error("Out-of-range transaction carries a nonzero coefficient.");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coefficient) && $stable(in_range))
    else $error("Stalled result changed before its transaction completed.");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input was refused while the output was free.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid after reset.");

endmodule

bind gabor_kernel_coefficient_core gkc_checker u_gkc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .coefficient (coefficient),
  .in_range    (in_range)
);

`default_nettype wire

// ===== tb/gabor_kernel_coefficient_core_test.sv =====
// Self-checking testbench of the Gabor kernel coefficient core with a scoreboard class.
`timescale 1ns / 100ps

module gabor_kernel_coefficient_core_test;
  import gkc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  class gabor_scoreboard;
    int unsigned side_w, side_h, lambda, theta, psi, sigma, gamma;
    logic signed [15:0] coef_q[$];
    logic range_q[$];
    int errors;

    function new();
      side_w = 10; side_h = 10; lambda = 5120; theta = 0;
      psi = 0; sigma = 1280; gamma = 128; errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_KERNEL_WIDTH:  side_w = data[6:0];
        REG_KERNEL_HEIGHT: side_h = data[6:0];
        REG_WAVELENGTH:    lambda = data[14:0];
        REG_ORIENTATION:   theta  = data[15:0];
        REG_PHASE_OFFSET:  psi    = data[13:0];
        REG_SPREAD:        sigma  = data[12:0];
        REG_ASPECT_RATIO:  gamma  = data[11:0];
        default: ;
      endcase
    endfunction

    function void add_expected(logic signed [15:0] coef, logic inr);
      coef_q.insert(coef_q.size(), coef);
      range_q.insert(range_q.size(), inr);
    endfunction

    function void rotate(longint turn, output longint c, output longint s);
      longint t, z, x, y, dx, dy;
      bit flip;
      t = turn & 64'hFFFF;
      flip = 0;
      x = 39797;
      y = 0;
      if (t >= 16384 && t < 49152) begin
        t -= 32768;
        flip = 1;
      end else if (t >= 49152) begin
        t -= 65536;
      end
      z = ((t < 0 ? -t : t) * 411775) >>> 16;
      if (t < 0) z = -z;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_q16(STEP_W'(i));
        end else begin
          x += dx; y -= dy; z += atan_q16(STEP_W'(i));
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint gauss(longint e);
      longint n, r, p;
      if (e >= (64'd12 << 16)) return 0;
      n = e / 45426;
      r = e - n * 45426;
      p = 65536;
      for (int k = 6; k >= 1; k--) p = 65536 - (r * p) / (k * 65536);
      return p >>> n;
    endfunction

    function void note(logic [COORD_W-1:0] col, logic [COORD_W-1:0] rw);
      longint w, h, ct, st, cph, sph, xt, yt, xr, yr, q, phi, ax, ay, e, env, m, mx, lam;
      longint thet, pst, sig;
      w = side_w > MAX_SIDE ? MAX_SIDE : side_w;
      h = side_h > MAX_SIDE ? MAX_SIDE : side_h;
      if (col >= w || rw >= h) begin
        add_expected(16'sd0, 1'b0);
        return;
      end
      thet = (longint'(theta) * 41722 + 32768) >>> 16;
      pst = (longint'(psi) * 2670205 + 32768) >>> 16;
      rotate(thet, ct, st);
      xt = w / 2 - col;
      yt = h / 2 - rw;
      xr = xt * ct + yt * st;
      yr = yt * ct - xt * st;
      lam = lambda ? lambda : 1;
      mx = xr < 0 ? -xr : xr;
      q = (mx * 256) / lam;
      if (xr < 0) q = -q;
      phi = (q + pst) & 64'hFFFF;
      rotate(phi, cph, sph);
      ax = mx >>> 8;
      ay = (yr < 0 ? -yr : yr) >>> 8;
      sig = sigma ? sigma : 1;
      e = ((ax * ax) << 16) + ay * ay * gamma * gamma;
      e = e / (2 * sig * sig);
      env = gauss(e);
      m = (env * (cph < 0 ? -cph : cph) + 65536) >>> 17;
      if (cph < 0) m = m > 32768 ? -32768 : -m;
      else m = m > 32767 ? 32767 : m;
      add_expected(16'(m), 1'b1);
    endfunction

    function void check(logic signed [15:0] coef, logic inr);
      if (coef_q.size() == 0) begin
        $display("%0t: unexpected result coefficient %0d in_range %0b", $time, coef, inr);
        errors++;
        return;
      end
      if (coef !== coef_q[0]) begin
        $display("%0t: coefficient expected %0d actual %0d", $time, coef_q[0], coef);
        errors++;
      end
      if (inr !== range_q[0]) begin
        $display("%0t: in_range expected %0b actual %0b", $time, range_q[0], inr);
        errors++;
      end
      void'(coef_q.pop_front());
      void'(range_q.pop_front());
    endfunction

    function int pending();
      return coef_q.size();
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, in_range;
  logic [COORD_W-1:0] column, row;
  logic signed [15:0] coefficient;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gabor_kernel_coefficient_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .column(column), .row(row),
    .out_valid(out_valid), .out_ready(out_ready),
    .coefficient(coefficient), .in_range(in_range),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gabor_scoreboard sb = new();
  bit in_taken, cfg_taken;
  int stall_mode, cyc;
  int burst_left;
  bit gapless;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  initial begin
    rst = 1'b1; in_valid = 0; column = '0; row = '0; out_ready = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    stall_mode = 0; cyc = 0; burst_left = 0; gapless = 0;
  end

  always @(posedge clk) begin
    in_taken = 0;
    cfg_taken = 0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_taken = 1;
        sb.note(column, row);
      end
      if (cfg_valid && cfg_ready) begin
        cfg_taken = 1;
        sb.write_reg(cfg_index, cfg_data);
      end
      if (out_valid && out_ready) sb.check(coefficient, in_range);
    end
  end

  always @(negedge clk) begin
    cyc++;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 99) >= 35);
      2: out_ready <= ((cyc % 23) < 15);
      default: out_ready <= ($urandom_range(0, 99) >= 80);
    endcase
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_taken);
  endtask

  task automatic send(logic [COORD_W-1:0] col, logic [COORD_W-1:0] rw);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = gapless ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    column <= col;
    row <= rw;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic pick_config(int ph);
    int w, h;
    case (ph)
      1: begin
        w = 1; h = 1;
        write_cfg(REG_WAVELENGTH, 16'd26); write_cfg(REG_ORIENTATION, 16'd0);
        write_cfg(REG_PHASE_OFFSET, 16'd0); write_cfg(REG_SPREAD, 16'd26);
        write_cfg(REG_ASPECT_RATIO, 16'd3);
      end
      2: begin
        w = 64; h = 64;
        write_cfg(REG_WAVELENGTH, 16'd25600); write_cfg(REG_ORIENTATION, 16'd51609);
        write_cfg(REG_PHASE_OFFSET, 16'd12800); write_cfg(REG_SPREAD, 16'd7680);
        write_cfg(REG_ASPECT_RATIO, 16'd2560);
      end
      3: begin
        w = 0; h = 127;
        write_cfg(REG_WAVELENGTH, 16'd0); write_cfg(REG_SPREAD, 16'd0);
      end
      4: begin
        w = 127; h = 0;
        write_cfg(REG_ORIENTATION, 16'hFFFF); write_cfg(REG_PHASE_OFFSET, 16'hFFFF);
        write_cfg(REG_WAVELENGTH, 16'hFFFF); write_cfg(REG_SPREAD, 16'hFFFF);
        write_cfg(REG_ASPECT_RATIO, 16'hFFFF);
      end
      5: begin
        w = 127; h = 127;
        write_cfg(REG_SPREAD, 16'd0); write_cfg(REG_ASPECT_RATIO, 16'd0);
        write_cfg(REG_WAVELENGTH, 16'd0);
        write_cfg(CFG_SPARE, 16'($urandom));
      end
      default: begin
        w = $urandom_range(1, 64); h = $urandom_range(1, 64);
        if ($urandom_range(0, 5) == 0) begin
          write_cfg(REG_WAVELENGTH, 16'($urandom));
          write_cfg(REG_ORIENTATION, 16'($urandom));
          write_cfg(REG_PHASE_OFFSET, 16'($urandom));
          write_cfg(REG_SPREAD, 16'($urandom));
          write_cfg(REG_ASPECT_RATIO, 16'($urandom));
        end else begin
          write_cfg(REG_WAVELENGTH, 16'($urandom_range(26, 25600)));
          write_cfg(REG_ORIENTATION, 16'($urandom_range(0, 51609)));
          write_cfg(REG_PHASE_OFFSET, 16'($urandom_range(0, 12800)));
          write_cfg(REG_SPREAD, 16'($urandom_range(26, 7680)));
          write_cfg(REG_ASPECT_RATIO, 16'($urandom_range(3, 2560)));
        end
        if ($urandom_range(0, 3) == 0) write_cfg(CFG_SPARE, 16'($urandom));
      end
    endcase
    write_cfg(REG_KERNEL_WIDTH, 16'(w));
    write_cfg(REG_KERNEL_HEIGHT, 16'(h));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int w, h;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(0, 0); send(63, 63); send(5, 5); send(9, 9); send(10, 0); send(0, 10);
    send(9, 0); send(0, 9); send(63, 0); send(0, 63); send(4, 6); send(6, 4);
    send(42, 21); send(21, 42); send(1, 8); send(8, 1);
    drain();

    for (int ph = 1; ph <= 16; ph++) begin
      stall_mode = ph % 4;
      gapless = (ph % 3 == 0);
      pick_config(ph);
      w = sb.side_w > MAX_SIDE ? MAX_SIDE : sb.side_w;
      h = sb.side_h > MAX_SIDE ? MAX_SIDE : sb.side_h;
      repeat (84) begin
        if ($urandom_range(0, 9) < 2 || w == 0 || h == 0)
          send(6'($urandom), 6'($urandom));
        else
          send(6'($urandom_range(0, w - 1)), 6'($urandom_range(0, h - 1)));
      end
      drain();
    end

    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("gabor_kernel_coefficient_core regression: pass");
    end else begin
      $display("gabor_kernel_coefficient_core regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("gabor_kernel_coefficient_core regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gkc_pkg.sv
rtl/gkc_cordic_cell.sv
rtl/gkc_div_cell.sv
rtl/gkc_exp_cell.sv
rtl/gabor_kernel_coefficient_core.sv
rtl/gkc_checker.sv
tb/gabor_kernel_coefficient_core_test.sv
